### rtl/gda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gda_pkg: shared types and constants for the date adder
// Field widths, calendar constants, sequencer states and month lengths.
// ----------------------------------------------------------------------------
package gda_pkg;

	localparam int DAY_W  = 5;
	localparam int MON_W  = 4;
	localparam int YEAR_W = 14;
	localparam int CNT_W  = 16;

	localparam int MAX_ADD_DAYS_DEF = 65535;
	localparam int TOP_YEAR_DEF     = 16383;

	localparam logic [YEAR_W-1:0] FIRST_YEAR = YEAR_W'(1601);
	localparam logic [YEAR_W-1:0] CYCLE_400  = YEAR_W'(400);
	localparam logic [YEAR_W-1:0] CENT_1     = YEAR_W'(100);
	localparam logic [YEAR_W-1:0] CENT_2     = YEAR_W'(200);
	localparam logic [YEAR_W-1:0] CENT_3     = YEAR_W'(300);
	localparam logic [YEAR_W-1:0] CYCLE_END  = YEAR_W'(399);

	localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
	localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
	localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);
	localparam logic [DAY_W-1:0] DAY_LAST_DEC = DAY_W'(31);
	localparam logic [DAY_W-1:0] DAY_LEAP_FEB = DAY_W'(29);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_RUN,
		ST_DONE
	} state_t;

	// Month length; zero for a month code outside 1..12.
	function automatic logic [DAY_W-1:0] days_in(input logic [MON_W-1:0] m,
		input logic leap);
		logic [DAY_W-1:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
			4'd4, 4'd6, 4'd9, 4'd11:                      len = DAY_W'(30);
			4'd2:                                        len = leap ? DAY_LEAP_FEB : DAY_W'(28);
			default:                                     len = '0;
		endcase
		return len;
	endfunction

endpackage

### rtl/gregorian_date_add_days.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days: Gregorian date plus a day count
// Checks a start date, then walks forward one month per cycle with a single
// subtract/compare unit under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                                         | handshake
//  --------+-------------------------------------------------+-----------------
//  input   | start_day, start_month, start_year, add_days    | in_valid/in_ready
//  output  | out_day, out_month, out_year, date_valid,       | out_valid/out_ready
//          | year_overflow                                   |
//
// One item at a time. Steps per item: accept, year mod-400 reduction (one
// subtraction of 400 per step), check, one step per month, final compare and
// result. An invalid date skips the month steps and the final compare; a
// top-year overflow ends the loop without the final compare.
// in_ready is high only while idle; the result is held until out_ready.
// Reset clears the sequencer only.
module gregorian_date_add_days #(
	parameter int MAX_ADD_DAYS = gda_pkg::MAX_ADD_DAYS_DEF,
	parameter int TOP_YEAR     = gda_pkg::TOP_YEAR_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [gda_pkg::DAY_W-1:0]   start_day,
	input  logic [gda_pkg::MON_W-1:0]   start_month,
	input  logic [gda_pkg::YEAR_W-1:0]  start_year,
	input  logic [gda_pkg::CNT_W-1:0]   add_days,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [gda_pkg::DAY_W-1:0]   out_day,
	output logic [gda_pkg::MON_W-1:0]   out_month,
	output logic [gda_pkg::YEAR_W-1:0]  out_year,
	output logic                        date_valid,
	output logic                        year_overflow
);

	// day accumulator holds start day plus the saturated count
	localparam int DW  = $clog2(MAX_ADD_DAYS + 32);
	localparam int NW  = (DW > gda_pkg::CNT_W) ? DW : gda_pkg::CNT_W;
	localparam int YCW = $clog2(TOP_YEAR + 1);
	localparam int YW  = (YCW > gda_pkg::YEAR_W) ? YCW : gda_pkg::YEAR_W;

	gda_pkg::state_t state_q, state_d;

	logic [DW-1:0]                 day_q;
	logic [DW-1:0]                 cnt_q;
	logic [gda_pkg::MON_W-1:0]     month_q;
	logic [YW-1:0]                 year_q;
	logic [gda_pkg::YEAR_W-1:0]    rem_q;
	logic                          valid_q;
	logic                          ovf_q;

	logic                          leap;
	logic [gda_pkg::DAY_W-1:0]     len;
	logic                          rem_big;
	logic                          date_ok;
	logic                          day_over;
	logic                          year_top;
	logic [NW-1:0]                 cnt_ext;
	logic [DW-1:0]                 cnt_sat;

	// rem_q is year mod 400 once the reduction is done
	assign leap = (year_q[1:0] == 2'b00) && (rem_q != gda_pkg::CENT_1) &&
		(rem_q != gda_pkg::CENT_2) && (rem_q != gda_pkg::CENT_3);
	assign len      = gda_pkg::days_in(month_q, leap);
	assign rem_big  = (rem_q >= gda_pkg::CYCLE_400);
	assign day_over = (day_q > DW'(len));
	assign year_top = (year_q >= YW'(TOP_YEAR));
	assign date_ok  = (year_q >= YW'(gda_pkg::FIRST_YEAR)) && (len != '0) &&
		(day_q != '0) && (day_q <= DW'(len));

	assign cnt_ext = NW'(add_days);
	assign cnt_sat = (cnt_ext > NW'(MAX_ADD_DAYS)) ? DW'(MAX_ADD_DAYS) : DW'(cnt_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gda_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = gda_pkg::ST_REDUCE;
			end
			gda_pkg::ST_REDUCE: begin
				if (!rem_big) state_d = gda_pkg::ST_CHECK;
			end
			gda_pkg::ST_CHECK: begin
				if (!date_ok || year_q > YW'(TOP_YEAR)) state_d = gda_pkg::ST_DONE;
				else state_d = gda_pkg::ST_RUN;
			end
			gda_pkg::ST_RUN: begin
				if (!day_over) state_d = gda_pkg::ST_DONE;
				else if (month_q == gda_pkg::MON_DEC && year_top) state_d = gda_pkg::ST_DONE;
			end
			gda_pkg::ST_DONE: begin
				out_valid = 1'b1;
				if (out_ready) state_d = gda_pkg::ST_IDLE;
			end
			default: state_d = gda_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			gda_pkg::ST_IDLE: begin
				if (in_valid) begin
					day_q   <= DW'(start_day);
					month_q <= start_month;
					year_q  <= YW'(start_year);
					rem_q   <= start_year;
					cnt_q   <= cnt_sat;
					valid_q <= 1'b0;
					ovf_q   <= 1'b0;
				end
			end
			gda_pkg::ST_REDUCE: begin
				if (rem_big) rem_q <= rem_q - gda_pkg::CYCLE_400;
			end
			gda_pkg::ST_CHECK: begin
				valid_q <= date_ok;
				if (date_ok) begin
					if (year_q > YW'(TOP_YEAR)) ovf_q <= 1'b1;
					else day_q <= day_q + cnt_q;
				end
			end
			gda_pkg::ST_RUN: begin
				if (day_over) begin
					day_q <= day_q - DW'(len);
					if (month_q == gda_pkg::MON_DEC) begin
						month_q <= gda_pkg::MON_JAN;
						if (year_top) begin
							ovf_q <= 1'b1;
						end else begin
							year_q <= year_q + YW'(1);
							rem_q  <= (rem_q == gda_pkg::CYCLE_END) ? '0 :
								rem_q + gda_pkg::YEAR_W'(1);
						end
					end else begin
						month_q <= month_q + gda_pkg::MON_W'(1);
					end
				end
			end
			gda_pkg::ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// overflow saturates to the last day of the top year
	assign out_day       = ovf_q ? gda_pkg::DAY_LAST_DEC : day_q[gda_pkg::DAY_W-1:0];
	assign out_month     = ovf_q ? gda_pkg::MON_DEC : month_q;
	assign out_year      = ovf_q ? gda_pkg::YEAR_W'(TOP_YEAR) : year_q[gda_pkg::YEAR_W-1:0];
	assign date_valid    = valid_q;
	assign year_overflow = ovf_q;

endmodule
